// File: rtl/core/cvcs_pkg.sv
// Shared types, constants and helpers of the cell voltage converter and stats block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cvcs_pkg;

	// Cells per group and the position of the last one.
	localparam int unsigned CELLS    = 6;
	localparam int unsigned POS_W    = 3;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(CELLS - 1);

	// Field widths.
	localparam int unsigned RAW_W  = 14;
	localparam int unsigned GAIN_W = 9;
	localparam int unsigned OFS_W  = 8;
	localparam int unsigned MV_W   = 13;
	localparam int unsigned SUM_W  = 16;
	localparam int unsigned TAG_W  = 4;

	// Register indexes of the configuration port.
	localparam logic REG_GAIN   = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	// Register reset values.
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 9'd380;
	localparam logic [OFS_W-1:0]  OFFSET_RESET = 8'd0;

	// floor(x / 1000) == ((x >> 3) * RECIP) >> RECIP_SHIFT, exact for x below 2^23.
	localparam int unsigned PROD_W      = RAW_W + GAIN_W;
	localparam int unsigned DIV_IN_W    = PROD_W - 3;
	localparam int unsigned RECIP_W     = 21;
	localparam logic [RECIP_W-1:0] RECIP = 21'd1073742;
	localparam int unsigned RECIP_SHIFT = 27;
	localparam int unsigned QPROD_W     = DIV_IN_W + RECIP_W;
	localparam int unsigned QUOT_W      = 14;

	localparam logic [MV_W-1:0]  MV_MAX   = '1;
	localparam logic [TAG_W-1:0] TAG_LAST = 4'd10;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [OFS_W-1:0]  offset;
	} cvcs_cfg_t;

	// One converted cell on its way from the front end to the stats unit.
	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [POS_W-1:0] pos;
	} cvcs_cell_t;

	function automatic logic [TAG_W-1:0] tap_label(input logic [POS_W-1:0] pos);
		logic [TAG_W-1:0] tag;
		case (pos)
			3'd0: tag = 4'd1;
			3'd1: tag = 4'd2;
			3'd2: tag = 4'd5;
			3'd3: tag = 4'd6;
			3'd4: tag = 4'd7;
			3'd5: tag = 4'd10;
			default: tag = 4'd0;
		endcase
		return tag;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/cvcs_front.sv
// Front end: accepts raw readings, tags the cell position, converts to millivolts.
// Depends on cvcs_pkg; pushes converted cells into cvcs_queue.
`timescale 1ns / 1ps
`default_nettype none

module cvcs_front #(
	parameter int unsigned QUEUE_DEPTH = 4,
	parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cvcs_pkg::cvcs_cfg_t           cfg,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [cvcs_pkg::RAW_W-1:0]    raw_reading,
	input  wire logic [CNT_W-1:0]              q_count,
	output logic                               push,
	output cvcs_pkg::cvcs_cell_t               push_cell
);
	import cvcs_pkg::*;

	localparam int unsigned OCC_W = CNT_W + 1;

	logic                 accept;
	logic [OCC_W-1:0]     occupancy;
	logic [POS_W-1:0]     pos_q;
	logic                 v_s1, v_s2;
	logic [PROD_W-1:0]    prod_s1;
	logic [POS_W-1:0]     pos_s1, pos_s2;
	logic [QPROD_W-1:0]   qprod_s2;
	logic [QUOT_W-1:0]    quot;
	logic signed [QUOT_W:0] level;

	// Reserve a queue slot for every item still in the conversion stages.
	assign occupancy = OCC_W'(q_count) + OCC_W'(v_s1) + OCC_W'(v_s2);
	assign in_ready  = occupancy < OCC_W'(QUEUE_DEPTH);
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
			end
		end
	end

	// Stage 1: raw times gain. Stage 2: divide by 1000 through the reciprocal.
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= PROD_W'(raw_reading) * PROD_W'(cfg.gain);
			pos_s1  <= pos_q;
		end
		qprod_s2 <= QPROD_W'(prod_s1[PROD_W-1:3]) * QPROD_W'(RECIP);
		pos_s2   <= pos_s1;
	end

	assign quot  = qprod_s2[RECIP_SHIFT +: QUOT_W];
	assign level = $signed({1'b0, quot}) + (QUOT_W+1)'($signed(cfg.offset));

	always_comb begin
		push          = v_s2;
		push_cell.pos = pos_s2;
		if (level < 0) begin
			push_cell.mv = '0;
		end else if (level > $signed({2'b00, MV_MAX})) begin
			push_cell.mv = MV_MAX;
		end else begin
			push_cell.mv = level[MV_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/cvcs_queue.sv
// Short queue between the conversion front end and the stats back end.
// Depends on cvcs_pkg for the cell type.
`timescale 1ns / 1ps
`default_nettype none

module cvcs_queue #(
	parameter int unsigned QUEUE_DEPTH = 4,
	parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire cvcs_pkg::cvcs_cell_t  push_cell,
	input  wire logic                  pop,
	output logic                       head_valid,
	output cvcs_pkg::cvcs_cell_t       head_cell,
	output logic [CNT_W-1:0]           count
);
	import cvcs_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	cvcs_cell_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign count      = count_q;
	assign head_valid = count_q != '0;
	assign head_cell  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/cvcs_back.sv
// Back end: running pack sum, first-wins max and min, and the output register.
// Depends on cvcs_pkg; pops cells from cvcs_queue.
`timescale 1ns / 1ps
`default_nettype none

module cvcs_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         head_valid,
	input  wire cvcs_pkg::cvcs_cell_t         head_cell,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [cvcs_pkg::MV_W-1:0]         cell_mv,
	output logic [cvcs_pkg::TAG_W-1:0]        cell_tag,
	output logic                              group_done,
	output logic [cvcs_pkg::SUM_W-1:0]        pack_mv,
	output logic [cvcs_pkg::MV_W-1:0]         highest_mv,
	output logic [cvcs_pkg::MV_W-1:0]         lowest_mv,
	output logic [cvcs_pkg::MV_W-1:0]         spread_mv,
	output logic [cvcs_pkg::TAG_W-1:0]        highest_tag,
	output logic [cvcs_pkg::TAG_W-1:0]        lowest_tag
);
	import cvcs_pkg::*;

	logic [SUM_W-1:0] sum_q, sum_d;
	logic [MV_W-1:0]  high_q, high_d, low_q, low_d;
	logic [POS_W-1:0] high_pos_q, high_pos_d, low_pos_q, low_pos_d;
	logic             first, last;
	logic             out_valid_q;

	logic [MV_W-1:0]  cell_mv_q, highest_mv_q, lowest_mv_q, spread_mv_q;
	logic [TAG_W-1:0] cell_tag_q, highest_tag_q, lowest_tag_q;
	logic             group_done_q;
	logic [SUM_W-1:0] pack_mv_q;

	// Advance when the output register is empty or being drained.
	assign pop = head_valid && (!out_valid_q || out_ready);

	assign first = head_cell.pos == '0;
	assign last  = head_cell.pos == LAST_POS;

	always_comb begin
		if (first) begin
			sum_d      = SUM_W'(head_cell.mv);
			high_d     = head_cell.mv;
			high_pos_d = '0;
			low_d      = head_cell.mv;
			low_pos_d  = '0;
		end else begin
			sum_d      = sum_q + SUM_W'(head_cell.mv);
			high_d     = high_q;
			high_pos_d = high_pos_q;
			low_d      = low_q;
			low_pos_d  = low_pos_q;
			if (head_cell.mv > high_q) begin
				high_d     = head_cell.mv;
				high_pos_d = head_cell.pos;
			end
			if (head_cell.mv < low_q) begin
				low_d     = head_cell.mv;
				low_pos_d = head_cell.pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			high_q      <= '0;
			high_pos_q  <= '0;
			low_q       <= '0;
			low_pos_q   <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				sum_q       <= sum_d;
				high_q      <= high_d;
				high_pos_q  <= high_pos_d;
				low_q       <= low_d;
				low_pos_q   <= low_pos_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stats fields read zero until the last cell of the group.
	always_ff @(posedge clk) begin
		if (pop) begin
			cell_mv_q     <= head_cell.mv;
			cell_tag_q    <= tap_label(head_cell.pos);
			group_done_q  <= last;
			pack_mv_q     <= last ? sum_d : '0;
			highest_mv_q  <= last ? high_d : '0;
			lowest_mv_q   <= last ? low_d : '0;
			spread_mv_q   <= last ? high_d - low_d : '0;
			highest_tag_q <= last ? tap_label(high_pos_d) : '0;
			lowest_tag_q  <= last ? tap_label(low_pos_d) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_mv     = cell_mv_q;
	assign cell_tag    = cell_tag_q;
	assign group_done  = group_done_q;
	assign pack_mv     = pack_mv_q;
	assign highest_mv  = highest_mv_q;
	assign lowest_mv   = lowest_mv_q;
	assign spread_mv   = spread_mv_q;
	assign highest_tag = highest_tag_q;
	assign lowest_tag  = lowest_tag_q;

endmodule

`default_nettype wire

// File: rtl/core/cell_voltage_convert_and_stats.sv
// Top level of the cell voltage converter and group statistics block.
// Depends on cvcs_pkg, cvcs_front, cvcs_queue and cvcs_back.
`timescale 1ns / 1ps
`default_nettype none

// One raw 14-bit ADC count per transfer on the input channel, cells in order,
// six cells to a group (tap labels 1, 2, 5, 6, 7, 10). Every input transfer
// yields exactly one output transfer: the cell in millivolts,
// floor(raw * gain / 1000) + offset clamped to 0..8191, and its tap label.
// The transfer of the sixth cell also carries group_done and the group's pack
// sum, highest, lowest, spread and the labels of the first cells holding the
// highest and lowest; on other transfers those fields read zero. The block
// sustains one reading per clock while the output does not stall. A cell
// passes, in order, the raw times gain register, which loads at the input
// transfer, then the reciprocal multiply that divides by 1000, the queue
// write and the output register, which raises out_valid. The input side
// takes a reading whenever the queue has room for it and for everything
// still in the multiplier stages. At full rate three of those places are
// in use, so QUEUE_DEPTH must be four or more to keep one reading per
// clock; while the output stalls, the input takes QUEUE_DEPTH minus three
// more readings and then holds in_ready low.
// Write gain (index 0) and offset (index 1) only while no transfer is in
// flight; the cell counter runs on across writes.
module cell_voltage_convert_and_stats #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [cvcs_pkg::GAIN_W-1:0]  cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cvcs_pkg::RAW_W-1:0]   raw_reading,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [cvcs_pkg::MV_W-1:0]         cell_mv,
	output logic [cvcs_pkg::TAG_W-1:0]        cell_tag,
	output logic                              group_done,
	output logic [cvcs_pkg::SUM_W-1:0]        pack_mv,
	output logic [cvcs_pkg::MV_W-1:0]         highest_mv,
	output logic [cvcs_pkg::MV_W-1:0]         lowest_mv,
	output logic [cvcs_pkg::MV_W-1:0]         spread_mv,
	output logic [cvcs_pkg::TAG_W-1:0]        highest_tag,
	output logic [cvcs_pkg::TAG_W-1:0]        lowest_tag
);
	import cvcs_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cvcs_cfg_t        cfg_q;
	logic             push, pop, head_valid;
	cvcs_cell_t       push_cell, head_cell;
	logic [CNT_W-1:0] q_count;

	// Configuration registers; the write lands at once, no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain   <= GAIN_RESET;
			cfg_q.offset <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:   cfg_q.gain   <= cfg_wdata;
				REG_OFFSET: cfg_q.offset <= cfg_wdata[OFS_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// Front end: accept, tag position, convert to millivolts.
	cvcs_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_reading (raw_reading),
		.q_count     (q_count),
		.push        (push),
		.push_cell   (push_cell)
	);

	// Queue decouples conversion from the stats and output side.
	cvcs_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cell  (push_cell),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cell  (head_cell),
		.count      (q_count)
	);

	// Back end: group statistics and the output register.
	cvcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cell   (head_cell),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_mv     (cell_mv),
		.cell_tag    (cell_tag),
		.group_done  (group_done),
		.pack_mv     (pack_mv),
		.highest_mv  (highest_mv),
		.lowest_mv   (lowest_mv),
		.spread_mv   (spread_mv),
		.highest_tag (highest_tag),
		.lowest_tag  (lowest_tag)
	);

	// Queue credit must keep the queue from overflowing.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(q_count) <= (CNT_W + 1)'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// A push into a full queue would drop a cell.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> (CNT_W + 1)'(q_count) < (CNT_W + 1)'(QUEUE_DEPTH))
		else $error("push into full queue");

	// Group end always lands on the last tap, with ordered extremes.
	a_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && group_done |-> cell_tag == TAG_LAST && highest_mv >= lowest_mv
			&& spread_mv == highest_mv - lowest_mv)
		else $error("inconsistent group statistics");

	// Stats fields pack_mv, highest_tag and lowest_tag stay zero mid-group, off the last tap.
	a_mid_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !group_done |-> pack_mv == '0 && highest_tag == '0
			&& lowest_tag == '0 && cell_tag != TAG_LAST)
		else $error("stats fields set before group end");

endmodule

`default_nettype wire
